[rtl/sibp_pkg.sv]
// ----------------------------------------------------------------------------
// sibp_pkg
// Shared types and constants for the segment index box parser.
// ----------------------------------------------------------------------------
package sibp_pkg;

  // Box type word, ASCII 'sidx'
  localparam logic [31:0] SIDX_TYPE = 32'h7369_6478;

  localparam int unsigned SIZE_W     = 31;  // referenced size width
  localparam int unsigned DUR_W      = 48;  // duration quotient width, Q32.16
  localparam int unsigned FRAC_W     = 16;  // fraction bits of the quotient
  localparam int unsigned SCALE_W    = 32;  // timescale width
  localparam int unsigned POS_W      = 32;  // byte position width
  localparam int unsigned ENTRY_IDX_W = 16;

  // Iterative divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = DUR_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Byte positions at which header fields complete
  localparam logic [POS_W-1:0] POS_LEN_END   = 32'd3;
  localparam logic [POS_W-1:0] POS_TYPE_END  = 32'd7;
  localparam logic [POS_W-1:0] POS_VER_END   = 32'd11;
  localparam logic [POS_W-1:0] POS_SCALE_END = 32'd19;
  localparam logic [POS_W-1:0] POS_HEAD_SHORT = 32'd31;
  localparam logic [POS_W-1:0] POS_HEAD_LONG  = 32'd39;

  // Entry end relative to head end: 12 bytes per entry, duration ends at +8
  localparam int unsigned ENTRY_END_W = 20;
  localparam logic [ENTRY_END_W-1:0] ENTRY_END_SHORT = 20'd39;
  localparam logic [ENTRY_END_W-1:0] ENTRY_END_LONG  = 20'd47;

  typedef enum logic [2:0] {
    ST_ENTRY_OK   = 3'd0,
    ST_OFFSET_OK  = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_INDEX_OUT  = 3'd4,
    ST_TRUNCATED  = 3'd5,
    ST_ZERO_SCALE = 3'd6
  } status_t;

endpackage

[rtl/sibp_div.sv]
// ----------------------------------------------------------------------------
// sibp_div
// Restoring divider, one quotient bit per cycle, for duration / timescale.
// ----------------------------------------------------------------------------
module sibp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sibp_pkg::DUR_W-1:0]        dividend,
  input  logic [sibp_pkg::SCALE_W-1:0]      divisor,
  output logic                              done,
  output logic [sibp_pkg::DUR_W-1:0]        quotient
);

  logic                               busy;
  logic [sibp_pkg::DIV_CNT_W-1:0]     count;
  logic [sibp_pkg::SCALE_W-1:0]       rem;
  logic [sibp_pkg::DUR_W-1:0]         quo;
  logic [sibp_pkg::SCALE_W-1:0]       dvs;

  logic [sibp_pkg::SCALE_W:0]         rem_shift;
  logic [sibp_pkg::SCALE_W:0]         rem_sub;
  logic                               ge;

  always_comb begin
    rem_shift = {rem, quo[sibp_pkg::DUR_W-1]};
    ge        = rem_shift >= {1'b0, dvs};
    rem_sub   = rem_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= sibp_pkg::DIV_CNT_W'(sibp_pkg::DIV_STEPS - 1);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= ge ? rem_sub[sibp_pkg::SCALE_W-1:0] : rem_shift[sibp_pkg::SCALE_W-1:0];
        quo   <= {quo[sibp_pkg::DUR_W-2:0], ge};
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[rtl/segment_index_box_parser_unit.sv]
// ----------------------------------------------------------------------------
// segment_index_box_parser_unit
// Byte-serial parser for an ISO BMFF segment index box with entry lookup.
// ----------------------------------------------------------------------------
// Feed the box one byte per item, big-endian, with last_byte on its final
// byte; box_size, entry_index and want_first_offset are sampled with the
// first byte. Each box gives exactly one result item: the first offset, or
// the chosen entry's size and duration/timescale (Q32.16), or an error
// status (wrong size, wrong type, index out of range, truncated box, zero
// timescale). Throughput: ordinary bytes are taken back to back. A byte that
// produces a result holds the input off until the result item is taken.
// A successful entry lookup runs the one-bit-per-cycle divider, and that
// byte holds the input off through the division and until its result is taken.
// Bytes after a result are dropped until last_byte, which restarts parsing.
// ----------------------------------------------------------------------------
module segment_index_box_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  box_byte,
  input  logic        last_byte,
  input  logic [31:0] box_size,
  input  logic [15:0] entry_index,
  input  logic        want_first_offset,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [30:0] entry_size,
  output logic [47:0] entry_duration,
  output logic [31:0] offset_low
);

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t state;

  // parser state
  logic [sibp_pkg::POS_W-1:0]       byte_position;
  logic [63:0]                      field_accumulator;
  logic                             long_fields;
  logic [sibp_pkg::SCALE_W-1:0]     time_scale;
  logic [31:0]                      saved_size;
  logic [sibp_pkg::ENTRY_IDX_W-1:0] saved_index;
  logic                             saved_mode;
  logic                             result_given;

  // per-byte decode
  logic                                byte_fire;
  logic [63:0]                         acc_next;
  logic [sibp_pkg::POS_W-1:0]          head_end;
  logic [sibp_pkg::ENTRY_END_W-1:0]    entry_end;
  logic                                res_fire;   // immediate result
  logic                                div_start;  // result after division
  sibp_pkg::status_t                   res_status;
  logic [31:0]                         res_offset;

  logic                                div_done;
  logic [sibp_pkg::DUR_W-1:0]          div_quotient;

  assign byte_fire  = byte_valid && !byte_stall;
  // one byte in flight: hold off while dividing or while a result waits
  assign byte_stall = (state != S_IDLE) || result_valid;

  assign acc_next = {field_accumulator[55:0], box_byte};
  assign head_end = long_fields ? sibp_pkg::POS_HEAD_LONG : sibp_pkg::POS_HEAD_SHORT;

  // head end + 12 * index + 8
  assign entry_end = ({4'b0, saved_index} << 3) + ({4'b0, saved_index} << 2)
                   + (long_fields ? sibp_pkg::ENTRY_END_LONG : sibp_pkg::ENTRY_END_SHORT);

  always_comb begin
    res_fire   = 1'b0;
    div_start  = 1'b0;
    res_status = sibp_pkg::ST_TRUNCATED;
    res_offset = '0;
    if (byte_fire && !result_given) begin
      if (byte_position == sibp_pkg::POS_LEN_END) begin
        if (acc_next[31:0] != saved_size) begin
          res_fire   = 1'b1;
          res_status = sibp_pkg::ST_BAD_SIZE;
        end
      end else if (byte_position == sibp_pkg::POS_TYPE_END) begin
        if (acc_next[31:0] != sibp_pkg::SIDX_TYPE) begin
          res_fire   = 1'b1;
          res_status = sibp_pkg::ST_BAD_TYPE;
        end
      end else if (byte_position == sibp_pkg::POS_VER_END ||
                   byte_position == sibp_pkg::POS_SCALE_END) begin
        // captured in the register block
      end else if (byte_position == head_end) begin
        if (saved_mode) begin
          res_fire   = 1'b1;
          res_status = sibp_pkg::ST_OFFSET_OK;
          res_offset = acc_next[63:32];
        end else if (saved_index >= acc_next[15:0]) begin
          res_fire   = 1'b1;
          res_status = sibp_pkg::ST_INDEX_OUT;
        end
      end else if (byte_position == {12'b0, entry_end}) begin
        if (time_scale == '0) begin
          res_fire   = 1'b1;
          res_status = sibp_pkg::ST_ZERO_SCALE;
        end else begin
          div_start  = 1'b1;
          res_status = sibp_pkg::ST_ENTRY_OK;
        end
      end
      // truncated box: last byte with nothing else to report
      if (!res_fire && !div_start && last_byte) begin
        res_fire   = 1'b1;
        res_status = sibp_pkg::ST_TRUNCATED;
      end
    end
  end

  sibp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({acc_next[31:0], sibp_pkg::FRAC_W'(0)}),
    .divisor  (time_scale),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_valid      <= 1'b0;
      byte_position     <= '0;
      field_accumulator <= '0;
      long_fields       <= 1'b0;
      time_scale        <= '0;
      saved_size        <= '0;
      saved_index       <= '0;
      saved_mode        <= 1'b0;
      result_given      <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state          <= S_IDLE;
            result_valid   <= 1'b1;
            entry_duration <= div_quotient;
          end
        end
        default: state <= S_IDLE;
      endcase

      // result payload
      if (res_fire) begin
        result_valid   <= 1'b1;
        status         <= res_status;
        entry_size     <= '0;
        entry_duration <= '0;
        offset_low     <= res_offset;
      end else if (div_start) begin
        status       <= res_status;
        entry_size   <= acc_next[62:32];
        offset_low   <= '0;
      end

      // parser registers
      if (byte_fire) begin
        if (last_byte) begin
          byte_position     <= '0;
          field_accumulator <= '0;
          long_fields       <= 1'b0;
          time_scale        <= '0;
          saved_size        <= '0;
          saved_index       <= '0;
          saved_mode        <= 1'b0;
          result_given      <= 1'b0;
        end else if (!result_given) begin
          field_accumulator <= acc_next;
          if (byte_position == '0) begin
            saved_size  <= box_size;
            saved_index <= entry_index;
            saved_mode  <= want_first_offset;
          end
          if (byte_position == sibp_pkg::POS_VER_END) begin
            long_fields <= acc_next[31:24] != 8'd0;
          end
          if (byte_position == sibp_pkg::POS_SCALE_END) begin
            time_scale <= acc_next[31:0];
          end
          if (res_fire || div_start) begin
            result_given <= 1'b1;
          end else begin
            byte_position <= byte_position + 1'b1;
          end
        end
      end
    end
  end

  // -- assertions -------------------------------------------------------------

  // the divider only reports while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside division state");

  // a division start always moves the sequencer into the wait state
  a_start_to_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV && !result_valid)
    else $error("division started without entering wait state");

  // only a good entry carries size and duration
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != sibp_pkg::ST_ENTRY_OK |->
      entry_size == '0 && entry_duration == '0)
    else $error("entry fields set on a non-entry result");

  // only an offset result carries the offset
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != sibp_pkg::ST_OFFSET_OK |-> offset_low == '0)
    else $error("offset set on a non-offset result");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment index box parser. Boxes are built
// byte by byte, fed over the valid/stall byte channel and every accepted
// byte is run through a local parser model; each result item is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;   // divider plus a long stall
  localparam int unsigned HOLD_CYCLES  = 300;   // receiver hold-off for the pressure test
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    sibp_pkg::status_t status;
    logic [30:0]       size;
    logic [47:0]       duration;
    logic [31:0]       offset;
  } box_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  box_byte = '0;
  logic        last_byte = 1'b0;
  logic [31:0] box_size = '0;
  logic [15:0] entry_index = '0;
  logic        want_first_offset = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  status;
  logic [30:0] entry_size;
  logic [47:0] entry_duration;
  logic [31:0] offset_low;

  // Bench control: quiet stretches turn off idling on both sides;
  // hold_req asks the receiver for one long hold-off.
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_total = 0;  // byte items sent so far

  box_result_t expected_results[$];
  logic [7:0]  box_q[$];          // box under construction

  // Local parser model state
  logic [31:0] m_pos;
  logic [63:0] m_acc;
  logic        m_long;
  logic [31:0] m_scale;
  logic [15:0] m_refs;
  logic [31:0] m_size;
  logic [15:0] m_index;
  logic        m_mode;
  logic        m_done;

  segment_index_box_parser_unit dut (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .byte_stall        (byte_stall),
    .box_byte          (box_byte),
    .last_byte         (last_byte),
    .box_size          (box_size),
    .entry_index       (entry_index),
    .want_first_offset (want_first_offset),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .status            (status),
    .entry_size        (entry_size),
    .entry_duration    (entry_duration),
    .offset_low        (offset_low)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  task automatic clear_parser_model();
    m_pos   = '0;
    m_acc   = '0;
    m_long  = 1'b0;
    m_scale = '0;
    m_refs  = '0;
    m_size  = '0;
    m_index = '0;
    m_mode  = 1'b0;
    m_done  = 1'b0;
  endtask

  // One accepted byte item in, at most one predicted result out.
  task automatic predict_box_byte(input logic [7:0] b, input logic last,
                                  input logic [31:0] sz, input logic [15:0] idx,
                                  input logic mode);
    box_result_t r;
    logic        hit;
    logic [31:0] p;
    logic [31:0] head_end;
    logic [31:0] entry_end;
    logic [63:0] quot;
    r   = '0;
    hit = 1'b0;
    if (!m_done) begin
      p = m_pos;
      if (p == 32'd0) begin
        m_size  = sz;
        m_index = idx;
        m_mode  = mode;
      end
      m_acc     = {m_acc[55:0], b};
      head_end  = m_long ? 32'd39 : 32'd31;
      // duration word of the chosen entry completes 8 bytes into the entry
      entry_end = head_end + 32'd12 * {16'd0, m_index} + 32'd8;

      if (p == 32'd3) begin
        if (m_acc[31:0] != m_size) begin
          hit = 1'b1;
          r.status = sibp_pkg::ST_BAD_SIZE;
        end
      end else if (p == 32'd7) begin
        if (m_acc[31:0] != sibp_pkg::SIDX_TYPE) begin
          hit = 1'b1;
          r.status = sibp_pkg::ST_BAD_TYPE;
        end
      end else if (p == 32'd11) begin
        m_long = (m_acc[31:24] != 8'd0);   // version byte
      end else if (p == 32'd19) begin
        m_scale = m_acc[31:0];
      end else if (p == head_end) begin
        // reference count done; first offset low word sits above it
        m_refs = m_acc[15:0];
        if (m_mode) begin
          hit = 1'b1;
          r.status = sibp_pkg::ST_OFFSET_OK;
          r.offset = m_acc[63:32];
        end else if (m_index >= m_refs) begin
          hit = 1'b1;
          r.status = sibp_pkg::ST_INDEX_OUT;
        end
      end else if (p > head_end && p == entry_end) begin
        hit = 1'b1;
        if (m_scale == 32'd0) begin
          r.status = sibp_pkg::ST_ZERO_SCALE;
        end else begin
          quot = {16'd0, m_acc[31:0], 16'd0} / {32'd0, m_scale};
          r.status   = sibp_pkg::ST_ENTRY_OK;
          r.size     = m_acc[62:32];
          r.duration = quot[47:0];
        end
      end

      if (hit) begin
        m_done = 1'b1;
      end else begin
        m_pos = p + 32'd1;
        if (last) begin
          hit = 1'b1;
          r.status = sibp_pkg::ST_TRUNCATED;
        end
      end
      if (hit) expected_results.push_back(r);
    end
    if (last) clear_parser_model();
  endtask

  task automatic check_parsed_result();
    box_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected result item: status %0d size %h dur %h offs %h",
                 status, entry_size, entry_duration, offset_low);
    end else begin
      want = expected_results.pop_front();
      if (status !== want.status || entry_size !== want.size ||
          entry_duration !== want.duration || offset_low !== want.offset) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch: exp status %0d size %h dur %h offs %h, got %0d %h %h %h",
                   want.status, want.size, want.duration, want.offset,
                   status, entry_size, entry_duration, offset_low);
      end
    end
  endtask

  // Input prediction and result check share one process, inputs first, so a
  // result never races its own expectation.
  always @(posedge clk) begin
    if (rst) begin
      clear_parser_model();
    end else begin
      if (byte_valid && !byte_stall)
        predict_box_byte(box_byte, last_byte, box_size, entry_index, want_first_offset);
      if (result_valid && !result_stall)
        check_parsed_result();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Idling
  // --------------------------------------------------------------------------
  // Mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stall runs, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        result_stall <= ($urandom_range(0, 2) == 0);
        repeat (1 + idle_length()) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offers one byte item and returns at the edge that takes it. Valid stays
  // high into the next item unless a gap is wanted.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] sz,
                           input logic [15:0] idx, input logic mode);
    int unsigned gap;
    gap = quiet ? 0 : idle_length();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    box_byte          <= b;
    last_byte         <= last;
    box_size          <= sz;
    entry_index       <= idx;
    want_first_offset <= mode;
    byte_valid        <= 1'b1;
    items_total++;
    do @(posedge clk); while (byte_stall);
  endtask

  // Sends box_q; the side fields only count on the first byte, so the rest
  // carry noise.
  task automatic send_box(input logic [31:0] sz, input logic [15:0] idx, input logic mode);
    int i;
    for (i = 0; i < box_q.size(); i++) begin
      if (i == 0)
        send_byte(box_q[i], box_q.size() == 1, sz, idx, mode);
      else
        send_byte(box_q[i], i == box_q.size() - 1, $urandom, 16'($urandom),
                  1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Box building
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [31:0] w);
    box_q.push_back(w[31:24]);
    box_q.push_back(w[23:16]);
    box_q.push_back(w[15:8]);
    box_q.push_back(w[7:0]);
  endtask

  task automatic set_word(input int at, input logic [31:0] w);
    box_q[at]     = w[31:24];
    box_q[at + 1] = w[23:16];
    box_q[at + 2] = w[15:8];
    box_q[at + 3] = w[7:0];
  endtask

  function automatic logic [31:0] length_word();
    return {box_q[0], box_q[1], box_q[2], box_q[3]};
  endfunction

  task automatic cut_box(input int n);
    while (box_q.size() > n) void'(box_q.pop_back());
  endtask

  // First byte of entry k
  function automatic int entry_base(input logic long_fmt, input int k);
    return (long_fmt ? 40 : 32) + 12 * k;
  endfunction

  // Well-formed box with random filler; length word set to the real length.
  task automatic make_box(input logic [7:0] version, input logic [31:0] scale,
                          input logic [63:0] offs, input logic [15:0] ref_count,
                          input int n_entries);
    box_q = {};
    push_word(32'd0);
    push_word(sibp_pkg::SIDX_TYPE);
    push_word({version, 24'($urandom)});
    push_word($urandom);                     // reference id
    push_word(scale);
    if (version != 8'd0) begin
      push_word($urandom);                   // 64-bit earliest time
      push_word($urandom);
      push_word(offs[63:32]);
    end else begin
      push_word($urandom);
    end
    push_word(offs[31:0]);
    box_q.push_back(8'($urandom));           // reserved
    box_q.push_back(8'($urandom));
    box_q.push_back(ref_count[15:8]);
    box_q.push_back(ref_count[7:0]);
    repeat (n_entries) begin
      push_word($urandom);                   // size word
      push_word($urandom);                   // duration
      push_word($urandom);                   // SAP word
    end
    set_word(0, 32'(box_q.size()));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_length_word();
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    cut_box(8);                              // rest would be dropped anyway
    send_box(length_word() ^ 32'h8000_0000, 16'd0, 1'b0);
    // zero length word accepted when it is what was asked for
    make_box(8'h00, 32'd48000, {$urandom, $urandom}, 16'd2, 2);
    set_word(0, 32'h0);
    send_box(32'h0, 16'd1, 1'b0);
    make_box(8'h01, 32'd90000, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 0);
    set_word(0, 32'hFFFF_FFFF);
    send_box(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    // mismatch completed by the last byte itself wins over truncation
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    cut_box(4);
    send_box(~length_word(), 16'd0, 1'b0);
  endtask

  task automatic test_type_word();
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    box_q[7] = 8'h79;                        // 'sidy'
    cut_box(12);
    send_box(length_word(), 16'd0, 1'b0);
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    box_q[4] ^= 8'h80;
    cut_box(12);
    send_box(length_word(), 16'd0, 1'b1);
  endtask

  task automatic test_truncation();
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    cut_box(1);                              // single-byte box
    send_box(length_word(), 16'd0, 1'b0);
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    cut_box(21);
    send_box(length_word(), 16'd0, 1'b0);
    make_box(8'h01, 32'd1000, 64'd0, 16'd1, 1);
    cut_box(36);                             // inside the long offset field
    send_box(length_word(), 16'd0, 1'b1);
  endtask

  task automatic test_first_offset();
    make_box(8'h00, 32'd1000, 64'h0000_0000_FFFF_FFFF, 16'd0, 0);
    send_box(length_word(), 16'd0, 1'b1);
    make_box(8'h01, 32'd1000, 64'hDEAD_BEEF_0000_0000, 16'd3, 0);
    send_box(length_word(), 16'd7, 1'b1);
    make_box(8'hFF, 32'd0, 64'h1234_5678_9ABC_DEF0, 16'hFFFF, 0);
    send_box(length_word(), 16'hFFFF, 1'b1);
  endtask

  task automatic test_entry_lookup();
    // largest size and quotient
    make_box(8'h00, 32'd1, 64'd0, 16'd1, 1);
    set_word(entry_base(1'b0, 0), 32'hFFFF_FFFF);
    set_word(entry_base(1'b0, 0) + 4, 32'hFFFF_FFFF);
    send_box(length_word(), 16'd0, 1'b0);
    // last entry, long fields, zero duration over the largest timescale
    make_box(8'h01, 32'hFFFF_FFFF, 64'd0, 16'd3, 3);
    set_word(entry_base(1'b1, 2) + 4, 32'h0);
    send_box(length_word(), 16'd2, 1'b0);
    // index equal to count, empty table, both at their top value
    make_box(8'h00, 32'd90000, 64'd0, 16'd2, 0);
    send_box(length_word(), 16'd2, 1'b0);
    make_box(8'h00, 32'd1000, 64'd0, 16'd0, 0);
    send_box(length_word(), 16'd0, 1'b0);
    make_box(8'h00, 32'd1000, 64'd0, 16'hFFFF, 0);
    send_box(length_word(), 16'hFFFF, 1'b0);
    // entry completed by the last byte
    make_box(8'h80, 32'd1000, 64'd0, 16'hFFFF, 1);
    cut_box(entry_base(1'b1, 0) + 8);
    send_box(length_word(), 16'd0, 1'b0);
    // zero timescale
    make_box(8'h00, 32'd0, 64'd0, 16'd1, 1);
    send_box(length_word(), 16'd0, 1'b0);
  endtask

  task automatic test_ignored_tail();
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    box_q[5] ^= 8'h01;
    cut_box(16);
    repeat (10) box_q.push_back(8'($urandom));
    send_box(length_word(), 16'd0, 1'b0);
    // parsing must restart cleanly after the dropped bytes
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    send_box(length_word(), 16'd0, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering bytes, so the parser
  // sits on its result and stalls the byte channel.
  task automatic test_back_pressure();
    quiet = 1'b1;
    byte_valid <= 1'b0;
    hold_req = 1'b1;
    while (hold_req) @(posedge clk);
    make_box(8'h00, 32'd1000, 64'd0, 16'd1, 1);
    cut_box(8);
    send_box(length_word() ^ 32'd1, 16'd0, 1'b0);
    make_box(8'h00, 32'd1000, {$urandom, $urandom}, 16'd1, 0);
    send_box(length_word(), 16'd0, 1'b1);
    make_box(8'h00, 32'd25, 64'd0, 16'd2, 2);
    send_box(length_word(), 16'd1, 1'b0);
    quiet = 1'b0;
  endtask

  // Mostly well-formed boxes with random content, the rest broken or noise.
  task automatic test_random();
    int unsigned boxes;
    int unsigned kind;
    logic [7:0]  version;
    logic [31:0] scale;
    logic [31:0] sz;
    logic [15:0] count;
    logic [15:0] idx;
    logic        mode;
    boxes = 0;
    while (items_total < 400 || boxes < 3) begin
      quiet   = ($urandom_range(0, 7) == 0);
      kind    = $urandom_range(0, 99);
      version = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
      count   = 16'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0:       scale = 32'd0;
        1, 2, 3: scale = $urandom_range(1, 1000);
        default: scale = $urandom;
      endcase
      make_box(version, scale, {$urandom, $urandom}, count, count);
      mode = (kind >= 60 && kind < 75);
      if ($urandom_range(0, 9) == 0)
        idx = 16'($urandom);
      else if (count != 0 && $urandom_range(0, 7) != 0)
        idx = 16'($urandom_range(0, count - 1));
      else
        idx = count;
      sz = length_word();
      if (kind >= 75) begin
        case ($urandom_range(0, 3))
          0: begin
            box_q = {};
            repeat ($urandom_range(1, 40)) box_q.push_back(8'($urandom));
            sz   = $urandom;
            mode = 1'($urandom);
          end
          1:       cut_box($urandom_range(1, box_q.size() - 1));
          2:       box_q[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
          default: sz = $urandom;
        endcase
      end
      // trailing bytes after the box proper
      if ($urandom_range(0, 9) < 3)
        repeat ($urandom_range(1, 6)) box_q.push_back(8'($urandom));
      send_box(sz, idx, mode);
      boxes++;
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_length_word();
    test_type_word();
    test_truncation();
    test_first_offset();
    test_entry_lookup();
    test_ignored_tail();
    test_back_pressure();
    test_random();

    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d predicted results never arrived", expected_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[segment_index_box_parser_unit.f]
rtl/sibp_pkg.sv
rtl/sibp_div.sv
rtl/segment_index_box_parser_unit.sv
test/tb_top.sv
